FILE: hw/rtl/tick_count_to_calendar_fields_assert.svh
// Assertion macros, clocked on clk and held off during rst
`ifndef TICK_COUNT_TO_CALENDAR_FIELDS_ASSERT_SVH
`define TICK_COUNT_TO_CALENDAR_FIELDS_ASSERT_SVH

`define TTCF_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

`define TTCF_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

FILE: hw/rtl/ttcf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ttcf_pkg;

  localparam longint unsigned TICK_HZ          = 64'd10_000_000;
  localparam longint unsigned SECS_PER_DAY     = 64'd86400;
  localparam longint unsigned SECS_PER_HOUR    = 64'd3600;
  localparam longint unsigned SECS_PER_MIN     = 64'd60;
  localparam longint unsigned DAY_TICKS        = TICK_HZ * SECS_PER_DAY;
  localparam longint unsigned TPMS_RAW         = TICK_HZ / 64'd1000;
  localparam longint unsigned TICKS_PER_MS     = (TPMS_RAW == 64'd0) ? 64'd1 : TPMS_RAW;

  localparam longint unsigned DAYS_1Y   = 64'd365;
  localparam longint unsigned DAYS_4Y   = 64'd1461;
  localparam longint unsigned DAYS_100Y = 64'd36524;
  localparam longint unsigned DAYS_400Y = 64'd146097;

  localparam int TICK_W = 62;
  localparam longint unsigned TICK_MAX = (64'd1 << TICK_W) - 64'd1;
  localparam longint unsigned DAY_MAX  = TICK_MAX / DAY_TICKS;

  localparam int DAY_W  = $clog2(DAY_MAX + 64'd1);
  localparam int TOD_W  = $clog2(DAY_TICKS);
  localparam int SUB_W  = $clog2(TICK_HZ);
  localparam int SEC_W  = $clog2(SECS_PER_DAY);
  localparam int MSQ_W  = $clog2((TICK_HZ - 64'd1) / TICKS_PER_MS + 64'd1);

  localparam int Q400_W = $clog2(DAY_MAX / DAYS_400Y + 64'd1);
  localparam int Q100_W = 2;
  localparam int Q4_W   = 5;
  localparam int Q1_W   = 2;
  localparam int DQ_W   = Q400_W + Q100_W + Q4_W + Q1_W;

  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DOM_W   = 5;
  localparam int DOY_W   = 9;
  localparam int HOUR_W  = 5;
  localparam int MIN_W   = 6;
  localparam int SECF_W  = 6;
  localparam int MS_W    = 10;
  localparam int HM_W    = HOUR_W + MIN_W;

  localparam logic [MS_W-1:0] MS_MAX = 10'd999;

  localparam int P2_LEN    = (MSQ_W > HM_W) ? MSQ_W : HM_W;
  localparam int LAT_SPLIT = DAY_W;
  localparam int LAT_DATE  = DQ_W + 3;
  localparam int LAT_CLOCK = SEC_W + P2_LEN + 1;
  localparam int LAT_TAIL  = (LAT_DATE > LAT_CLOCK) ? LAT_DATE : LAT_CLOCK;
  localparam int PAD_DATE  = LAT_TAIL - LAT_DATE;
  localparam int PAD_CLOCK = LAT_TAIL - LAT_CLOCK;
  localparam int LAT_TOTAL = LAT_SPLIT + LAT_TAIL;

  typedef struct packed {
    logic [DAY_W-1:0] days;
    logic [TOD_W-1:0] tod;
  } split_t;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DOM_W-1:0]   day_of_month;
    logic [DOY_W-1:0]   day_of_year;
    logic               leap_year;
  } date_t;

  typedef struct packed {
    logic [HOUR_W-1:0] hours;
    logic [MIN_W-1:0]  minutes;
    logic [SECF_W-1:0] seconds;
    logic [MS_W-1:0]   milliseconds;
  } clock_t;

  // shifted divisor for each restoring step of the day breakdown
  function automatic longint unsigned date_step(input int g);
    if (g < Q400_W) begin
      return DAYS_400Y << (Q400_W - 1 - g);
    end else if (g < Q400_W + Q100_W) begin
      return DAYS_100Y << (Q400_W + Q100_W - 1 - g);
    end else if (g < Q400_W + Q100_W + Q4_W) begin
      return DAYS_4Y << (Q400_W + Q100_W + Q4_W - 1 - g);
    end else begin
      return DAYS_1Y << (DQ_W - 1 - g);
    end
  endfunction

  function automatic longint unsigned hm_step(input int g);
    if (g < HOUR_W) begin
      return SECS_PER_HOUR << (HOUR_W - 1 - g);
    end else begin
      return SECS_PER_MIN << (HM_W - 1 - g);
    end
  endfunction

  // days before the start of month idx+1
  function automatic logic [DOY_W-1:0] cum_days(input logic [MONTH_W-1:0] idx,
                                                input logic leap);
    logic [DOY_W-1:0] base;
    unique case (idx)
      4'd0:    base = 9'd0;
      4'd1:    base = 9'd31;
      4'd2:    base = 9'd59;
      4'd3:    base = 9'd90;
      4'd4:    base = 9'd120;
      4'd5:    base = 9'd151;
      4'd6:    base = 9'd181;
      4'd7:    base = 9'd212;
      4'd8:    base = 9'd243;
      4'd9:    base = 9'd273;
      4'd10:   base = 9'd304;
      4'd11:   base = 9'd334;
      4'd12:   base = 9'd365;
      default: base = 9'd0;
    endcase
    return (leap && (idx >= 4'd2)) ? base + 9'd1 : base;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/ttcf_day_split.sv
`timescale 1ns / 1ps
`default_nettype none

module ttcf_day_split
  import ttcf_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire logic [TICK_W-1:0] ticks,
  output logic                   out_valid,
  output split_t                 result
);

  logic [DAY_W-1:0]  vld;
  logic [TICK_W-1:0] rem [DAY_W];
  logic [DAY_W-1:0]  quo [DAY_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[DAY_W-2:0], in_valid};
    end
  end

  // one quotient bit per stage, msb first
  for (genvar g = 0; g < DAY_W; g++) begin : g_step
    localparam int B = DAY_W - 1 - g;
    localparam logic [TICK_W-1:0] SD = TICK_W'(DAY_TICKS << B);
    logic [TICK_W-1:0] r_in;
    logic [DAY_W-1:0]  q_in;
    if (g == 0) begin : g_first
      assign r_in = ticks;
      assign q_in = '0;
    end else begin : g_next
      assign r_in = rem[g-1];
      assign q_in = quo[g-1];
    end
    always_ff @(posedge clk) begin
      if (r_in >= SD) begin
        rem[g] <= r_in - SD;
        quo[g] <= q_in | (DAY_W'(1) << B);
      end else begin
        rem[g] <= r_in;
        quo[g] <= q_in;
      end
    end
  end

  assign out_valid   = vld[DAY_W-1];
  assign result.days = quo[DAY_W-1];
  assign result.tod  = rem[DAY_W-1][TOD_W-1:0];

endmodule

`default_nettype wire

FILE: hw/rtl/ttcf_date.sv
`timescale 1ns / 1ps
`default_nettype none

module ttcf_date
  import ttcf_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  input  wire logic [DAY_W-1:0] days,
  output logic                  out_valid,
  output date_t                 result
);

  logic [LAT_DATE-1:0] vld;
  logic [DAY_W-1:0]    rem [DQ_W];
  logic [DQ_W-1:0]     quo [DQ_W];

  logic [Q400_W-1:0]  q400;
  logic [Q100_W-1:0]  q100;
  logic [Q4_W-1:0]    q4;
  logic [Q1_W-1:0]    q1;
  logic [DOY_W-1:0]   r_doy;

  logic [YEAR_W-1:0]  y_year;
  logic               y_leap;
  logic [DOY_W-1:0]   y_doy;

  logic [MONTH_W-1:0] mon_next;
  logic [MONTH_W-1:0] m_mon;
  logic [YEAR_W-1:0]  m_year;
  logic               m_leap;
  logic [DOY_W-1:0]   m_doy;
  logic [DOY_W-1:0]   dom_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LAT_DATE-2:0], in_valid};
    end
  end

  // 400-, 100-, 4- and 1-year periods; the short 100y and 1y quotients clamp at 3
  for (genvar g = 0; g < DQ_W; g++) begin : g_step
    localparam int B = DQ_W - 1 - g;
    localparam logic [DAY_W-1:0] SD = DAY_W'(date_step(g));
    logic [DAY_W-1:0] r_in;
    logic [DQ_W-1:0]  q_in;
    if (g == 0) begin : g_first
      assign r_in = days;
      assign q_in = '0;
    end else begin : g_next
      assign r_in = rem[g-1];
      assign q_in = quo[g-1];
    end
    always_ff @(posedge clk) begin
      if (r_in >= SD) begin
        rem[g] <= r_in - SD;
        quo[g] <= q_in | (DQ_W'(1) << B);
      end else begin
        rem[g] <= r_in;
        quo[g] <= q_in;
      end
    end
  end

  assign {q400, q100, q4, q1} = quo[DQ_W-1];
  assign r_doy = rem[DQ_W-1][DOY_W-1:0];

  always_ff @(posedge clk) begin
    y_year <= YEAR_W'(q400) * YEAR_W'(400) + YEAR_W'(q100) * YEAR_W'(100)
            + YEAR_W'({q4, 2'b00}) + YEAR_W'(q1) + YEAR_W'(1);
    y_leap <= (q1 == 2'd3) && ((q4 != 5'd24) || (q100 == 2'd3));
    y_doy  <= r_doy;
  end

  always_comb begin
    mon_next = 4'd1;
    for (int k = 1; k < 12; k++) begin
      if (y_doy >= cum_days(MONTH_W'(k), y_leap)) begin
        mon_next = MONTH_W'(k + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    m_mon  <= mon_next;
    m_year <= y_year;
    m_leap <= y_leap;
    m_doy  <= y_doy;
  end

  assign dom_full = m_doy - cum_days(m_mon - 4'd1, m_leap) + 9'd1;

  always_ff @(posedge clk) begin
    result.year         <= m_year;
    result.month        <= m_mon;
    result.day_of_month <= dom_full[DOM_W-1:0];
    result.day_of_year  <= m_doy + 9'd1;
    result.leap_year    <= m_leap;
  end

  assign out_valid = vld[LAT_DATE-1];

endmodule

`default_nettype wire

FILE: hw/rtl/ttcf_clock.sv
`timescale 1ns / 1ps
`default_nettype none

module ttcf_clock
  import ttcf_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  input  wire logic [TOD_W-1:0] tod,
  output logic                  out_valid,
  output clock_t                result
);

  logic [LAT_CLOCK-1:0] vld;
  logic [TOD_W-1:0]     srem [SEC_W];
  logic [SEC_W-1:0]     squo [SEC_W];
  logic [SEC_W-1:0]     hrem [P2_LEN];
  logic [HM_W-1:0]      hquo [P2_LEN];
  logic [SUB_W-1:0]     mrem [P2_LEN];
  logic [MSQ_W-1:0]     mquo [P2_LEN];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LAT_CLOCK-2:0], in_valid};
    end
  end

  // whole seconds of the day
  for (genvar g = 0; g < SEC_W; g++) begin : g_sec
    localparam int B = SEC_W - 1 - g;
    localparam logic [TOD_W-1:0] SD = TOD_W'(TICK_HZ << B);
    logic [TOD_W-1:0] r_in;
    logic [SEC_W-1:0] q_in;
    if (g == 0) begin : g_first
      assign r_in = tod;
      assign q_in = '0;
    end else begin : g_next
      assign r_in = srem[g-1];
      assign q_in = squo[g-1];
    end
    always_ff @(posedge clk) begin
      if (r_in >= SD) begin
        srem[g] <= r_in - SD;
        squo[g] <= q_in | (SEC_W'(1) << B);
      end else begin
        srem[g] <= r_in;
        squo[g] <= q_in;
      end
    end
  end

  // hours/minutes from the seconds and milliseconds from the sub-second ticks, side by side
  for (genvar g = 0; g < P2_LEN; g++) begin : g_sub
    logic [SEC_W-1:0] hr_in;
    logic [HM_W-1:0]  hq_in;
    logic [SUB_W-1:0] mr_in;
    logic [MSQ_W-1:0] mq_in;
    if (g == 0) begin : g_first
      assign hr_in = squo[SEC_W-1];
      assign hq_in = '0;
      assign mr_in = srem[SEC_W-1][SUB_W-1:0];
      assign mq_in = '0;
    end else begin : g_next
      assign hr_in = hrem[g-1];
      assign hq_in = hquo[g-1];
      assign mr_in = mrem[g-1];
      assign mq_in = mquo[g-1];
    end

    if (g < HM_W) begin : g_hm
      localparam int B = HM_W - 1 - g;
      localparam logic [SEC_W-1:0] SD = SEC_W'(hm_step(g));
      always_ff @(posedge clk) begin
        if (hr_in >= SD) begin
          hrem[g] <= hr_in - SD;
          hquo[g] <= hq_in | (HM_W'(1) << B);
        end else begin
          hrem[g] <= hr_in;
          hquo[g] <= hq_in;
        end
      end
    end else begin : g_hm_hold
      always_ff @(posedge clk) begin
        hrem[g] <= hr_in;
        hquo[g] <= hq_in;
      end
    end

    if (g < MSQ_W) begin : g_ms
      localparam int B = MSQ_W - 1 - g;
      localparam logic [SUB_W-1:0] SD = SUB_W'(TICKS_PER_MS << B);
      always_ff @(posedge clk) begin
        if (mr_in >= SD) begin
          mrem[g] <= mr_in - SD;
          mquo[g] <= mq_in | (MSQ_W'(1) << B);
        end else begin
          mrem[g] <= mr_in;
          mquo[g] <= mq_in;
        end
      end
    end else begin : g_ms_hold
      always_ff @(posedge clk) begin
        mrem[g] <= mr_in;
        mquo[g] <= mq_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    result.hours   <= hquo[P2_LEN-1][HM_W-1 -: HOUR_W];
    result.minutes <= hquo[P2_LEN-1][MIN_W-1:0];
    result.seconds <= hrem[P2_LEN-1][SECF_W-1:0];
    result.milliseconds <= (mquo[P2_LEN-1] > MSQ_W'(MS_MAX)) ? MS_MAX
                                                             : MS_W'(mquo[P2_LEN-1]);
  end

  assign out_valid = vld[LAT_CLOCK-1];

endmodule

`default_nettype wire

FILE: hw/rtl/tick_count_to_calendar_fields.sv
// channel  dir  handshake                    payload
// command  in   start, taken when busy low   elapsed_ticks
// result   out  done, high for one cycle     year .. milliseconds
//
// One item enters per cycle while busy is low. Each result passes one restoring
// divider stage per quotient bit: first days and time of day, then calendar and
// clock fields in parallel lanes.
// rst clears the valid chain; busy is high only while rst is high.
// Nothing stalls: the receiver cannot hold off a result.
`timescale 1ns / 1ps
`default_nettype none
`include "tick_count_to_calendar_fields_assert.svh"

module tick_count_to_calendar_fields
  import ttcf_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [TICK_W-1:0] elapsed_ticks,
  output logic                   done,
  output logic [YEAR_W-1:0]      year,
  output logic [MONTH_W-1:0]     month,
  output logic [DOM_W-1:0]       day_of_month,
  output logic [DOY_W-1:0]       day_of_year,
  output logic                   leap_year,
  output logic [HOUR_W-1:0]      hours,
  output logic [MIN_W-1:0]       minutes,
  output logic [SECF_W-1:0]      seconds,
  output logic [MS_W-1:0]        milliseconds
);

  logic   accept;
  logic   split_vld;
  split_t split_res;
  logic   date_vld;
  date_t  date_res;
  logic   clock_vld;
  clock_t clock_res;
  logic   date_out_vld;
  date_t  date_out;
  logic   clock_out_vld;
  clock_t clock_out;

  assign busy   = rst;
  assign accept = start && !busy;

  ttcf_day_split u_split (
    .clk      (clk),
    .rst      (rst),
    .in_valid (accept),
    .ticks    (elapsed_ticks),
    .out_valid(split_vld),
    .result   (split_res)
  );

  ttcf_date u_date (
    .clk      (clk),
    .rst      (rst),
    .in_valid (split_vld),
    .days     (split_res.days),
    .out_valid(date_vld),
    .result   (date_res)
  );

  ttcf_clock u_clock (
    .clk      (clk),
    .rst      (rst),
    .in_valid (split_vld),
    .tod      (split_res.tod),
    .out_valid(clock_vld),
    .result   (clock_res)
  );

  // line up the shorter lane with the longer one
  if (PAD_DATE > 0) begin : g_pad_date
    logic  pv [PAD_DATE];
    date_t pd [PAD_DATE];
    for (genvar i = 0; i < PAD_DATE; i++) begin : g_stage
      logic  v_in;
      date_t d_in;
      if (i == 0) begin : g_first
        assign v_in = date_vld;
        assign d_in = date_res;
      end else begin : g_next
        assign v_in = pv[i-1];
        assign d_in = pd[i-1];
      end
      always_ff @(posedge clk) begin
        if (rst) begin
          pv[i] <= 1'b0;
        end else begin
          pv[i] <= v_in;
        end
      end
      always_ff @(posedge clk) begin
        pd[i] <= d_in;
      end
    end
    assign date_out_vld = pv[PAD_DATE-1];
    assign date_out     = pd[PAD_DATE-1];
  end else begin : g_nopad_date
    assign date_out_vld = date_vld;
    assign date_out     = date_res;
  end

  if (PAD_CLOCK > 0) begin : g_pad_clock
    logic   pv [PAD_CLOCK];
    clock_t pd [PAD_CLOCK];
    for (genvar i = 0; i < PAD_CLOCK; i++) begin : g_stage
      logic   v_in;
      clock_t d_in;
      if (i == 0) begin : g_first
        assign v_in = clock_vld;
        assign d_in = clock_res;
      end else begin : g_next
        assign v_in = pv[i-1];
        assign d_in = pd[i-1];
      end
      always_ff @(posedge clk) begin
        if (rst) begin
          pv[i] <= 1'b0;
        end else begin
          pv[i] <= v_in;
        end
      end
      always_ff @(posedge clk) begin
        pd[i] <= d_in;
      end
    end
    assign clock_out_vld = pv[PAD_CLOCK-1];
    assign clock_out     = pd[PAD_CLOCK-1];
  end else begin : g_nopad_clock
    assign clock_out_vld = clock_vld;
    assign clock_out     = clock_res;
  end

  assign done         = date_out_vld;
  assign year         = date_out.year;
  assign month        = date_out.month;
  assign day_of_month = date_out.day_of_month;
  assign day_of_year  = date_out.day_of_year;
  assign leap_year    = date_out.leap_year;
  assign hours        = clock_out.hours;
  assign minutes      = clock_out.minutes;
  assign seconds      = clock_out.seconds;
  assign milliseconds = clock_out.milliseconds;

  `TTCF_ASSERT_ALWAYS(a_lanes_aligned, date_out_vld == clock_out_vld, "lanes out of step")
  `TTCF_ASSERT_IMPLY(a_latency, done, $past(accept, LAT_TOTAL), "result without its item")
  `TTCF_ASSERT_IMPLY(a_result_due, accept, ##LAT_TOTAL done, "item without its result")
  `TTCF_ASSERT_IMPLY(a_doy_common, done && !leap_year, day_of_year <= 9'd365, "bad day of year")
  `TTCF_ASSERT_IMPLY(a_date, done, ((month - 4'd1) < 4'd12) && (day_of_month != 5'd0), "bad date")

endmodule

`default_nettype wire
